[rtl/bms_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bms_pkg
// Shared types, tone tables and register indexes for the button melody
// sequencer.
// ----------------------------------------------------------------------------
package bms_pkg;

  // Sequencer phases, coded as they appear on phase_code.
  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_WAIT  = 3'd1,
    PH_NOTE  = 3'd2,
    PH_REST  = 3'd3,
    PH_HOLD  = 3'd4
  } phase_t;

  // Tone code: 0 is silence, 1 to 6 are A, E, D, C5, B and G.
  typedef logic [2:0] tone_t;

  localparam tone_t TONE_SILENT = 3'd0;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_NOTE_TICKS = 2'd0,
    REG_REST_TICKS = 2'd1,
    REG_LAST_STEP  = 2'd2
  } reg_index_t;

  localparam int unsigned NOTE_STEPS_DEFAULT = 16;
  localparam int unsigned MELODY_LEN         = 16;

  localparam logic [7:0] BUTTON_PRESS   = 8'h01;
  localparam logic [7:0] BUTTON_RELEASE = 8'h00;

  localparam logic [7:0]  NOTE_TICKS_RESET = 8'd1;
  localparam logic [7:0]  REST_TICKS_RESET = 8'd1;
  localparam logic [3:0]  LAST_STEP_RESET  = 4'd15;

  // Divider compare word per tone code: 8000000 / (128 * f) truncated, minus 1.
  // Entry 0 is the rightmost element.
  localparam logic [7:0][15:0] TONE_WORD = {
    16'hFFFF, 16'd158, 16'd125, 16'd118, 16'd211, 16'd188, 16'd141, 16'hFFFF
  };

  // Fixed melody, step 0 is the rightmost element.
  localparam logic [MELODY_LEN-1:0][2:0] MELODY = {
    3'd1, 3'd5, 3'd6, 3'd5, 3'd4, 3'd3, 3'd4, 3'd5,
    3'd1, 3'd5, 3'd4, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1
  };

endpackage
`default_nettype wire

[rtl/button_melody_sequencer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// button_melody_sequencer
// Button-started melody player that emits one tone status per tick.
// ----------------------------------------------------------------------------
// Each input transaction is one tick carrying the sampled button byte, and it
// produces exactly one output transaction in the next cycle with the tone gate,
// the tone divider compare word, a restart strobe, the phase and the step.
// The block takes one tick per clock cycle: the next phase, step, tick count
// and tone are worked out by a short block of logic from the state registers
// and the incoming byte, and land in the state registers and in an output
// register in the same edge. A new tick is accepted whenever the output
// register is empty or is being drained in that cycle, so with no stall on
// the output side the throughput is one transaction per cycle. Configuration
// registers (note_ticks, rest_ticks, last_step) are written through a plain
// write port and should only be changed while no tick is in flight. After
// reset the sequencer passes through a start phase into wait; a byte equal
// to 1 starts play of a fixed note table, each step being a note phase
// followed by a rest phase timed by a wrapping 8-bit tick counter that is
// deliberately not cleared between a rest and the following note.
module button_melody_sequencer #(
  parameter int unsigned NOTE_STEPS = bms_pkg::NOTE_STEPS_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // Tick input channel.
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  button_byte,
  // Result channel.
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             tone_on,
  output logic [15:0]      tone_compare,
  output logic             restart_counter,
  output logic [2:0]       phase_code,
  output logic [3:0]       step_index,
  // Configuration write port.
  input  wire logic        cfg_write_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [7:0]  cfg_data
);

  // Tone per step, with steps past the table folded back onto it. The fold
  // is fixed at elaboration, so this is a constant table.
  logic [2:0] step_tone [16];

  for (genvar i = 0; i < 16; i++) begin : g_step_tone
    localparam int unsigned IDX = (i % NOTE_STEPS) % bms_pkg::MELODY_LEN;
    assign step_tone[i] = bms_pkg::MELODY[IDX[3:0]];
  end

  // Configuration registers.
  logic [7:0] note_ticks;
  logic [7:0] rest_ticks;
  logic [3:0] last_step;

  // Sequencer state.
  bms_pkg::phase_t phase, phase_next;
  logic [3:0]      step, step_next;
  logic [7:0]      tick_count, tick_count_next;
  bms_pkg::tone_t  last_tone, last_tone_next;
  logic            restart_next;

  logic in_accept;
  logic out_accept;

  // The output register can take a new result when it is empty or when its
  // current content leaves in this cycle.
  assign out_accept = out_valid & ~out_stall;
  assign in_stall   = out_valid & out_stall;
  assign in_accept  = in_valid & ~in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      note_ticks <= bms_pkg::NOTE_TICKS_RESET;
      rest_ticks <= bms_pkg::REST_TICKS_RESET;
      last_step  <= bms_pkg::LAST_STEP_RESET;
    end else if (cfg_write_en) begin
      case (cfg_index)
        bms_pkg::REG_NOTE_TICKS: note_ticks <= cfg_data;
        bms_pkg::REG_REST_TICKS: rest_ticks <= cfg_data;
        bms_pkg::REG_LAST_STEP:  last_step  <= cfg_data[3:0];
        default: ;  // Unknown indexes are ignored.
      endcase
    end
  end

  // Next phase, step and tick count. Leaving a rest for the next note keeps
  // the tick count running; only the start phase, entering a note from wait
  // and entering a rest clear it. A final rest that sees neither a release nor
  // a press keeps resting and counting.
  always_comb begin
    phase_next      = phase;
    step_next       = step;
    tick_count_next = tick_count;
    case (phase)
      bms_pkg::PH_START: begin
        phase_next      = bms_pkg::PH_WAIT;
        step_next       = '0;
        tick_count_next = '0;
      end
      bms_pkg::PH_WAIT: begin
        if (button_byte == bms_pkg::BUTTON_PRESS) begin
          phase_next      = bms_pkg::PH_NOTE;
          tick_count_next = '0;
        end
      end
      bms_pkg::PH_NOTE: begin
        if (tick_count >= note_ticks) begin
          phase_next      = bms_pkg::PH_REST;
          tick_count_next = '0;
        end
      end
      bms_pkg::PH_REST: begin
        if (tick_count >= rest_ticks) begin
          if (step < last_step) begin
            step_next  = step + 4'd1;
            phase_next = bms_pkg::PH_NOTE;
          end else if (button_byte == bms_pkg::BUTTON_RELEASE) begin
            step_next  = '0;
            phase_next = bms_pkg::PH_WAIT;
          end else if (button_byte == bms_pkg::BUTTON_PRESS) begin
            step_next  = '0;
            phase_next = bms_pkg::PH_HOLD;
          end
        end
      end
      bms_pkg::PH_HOLD: begin
        if (button_byte != bms_pkg::BUTTON_PRESS) begin
          phase_next = bms_pkg::PH_WAIT;
          step_next  = '0;
        end
      end
      default: phase_next = bms_pkg::PH_WAIT;
    endcase
    // Note and rest phases count this tick.
    if (phase_next == bms_pkg::PH_NOTE || phase_next == bms_pkg::PH_REST) begin
      tick_count_next = tick_count_next + 8'd1;
    end
  end

  // Tone selected by the new phase, and the restart strobe when it changes.
  // End hold keeps whatever tone was last selected.
  always_comb begin
    case (phase_next)
      bms_pkg::PH_NOTE: last_tone_next = step_tone[step_next];
      bms_pkg::PH_HOLD: last_tone_next = last_tone;
      default:          last_tone_next = bms_pkg::TONE_SILENT;
    endcase
    restart_next = (last_tone_next != last_tone);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= bms_pkg::PH_START;
      step       <= '0;
      tick_count <= '0;
      last_tone  <= bms_pkg::TONE_SILENT;
      out_valid  <= 1'b0;
    end else begin
      if (in_accept) begin
        phase      <= phase_next;
        step       <= step_next;
        tick_count <= tick_count_next;
        last_tone  <= last_tone_next;
        out_valid  <= 1'b1;
      end else if (out_accept) begin
        out_valid  <= 1'b0;
      end
    end
  end

  // Output payload register; loaded only with an accepted tick.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      tone_on         <= (last_tone_next != bms_pkg::TONE_SILENT);
      tone_compare    <= bms_pkg::TONE_WORD[last_tone_next];
      restart_counter <= restart_next;
      phase_code      <= phase_next;
      step_index      <= step_next;
    end
  end

endmodule
`default_nettype wire

[rtl/bms_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bms_checker
// Port-level assertions for the button melody sequencer.
// ----------------------------------------------------------------------------
module bms_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        tone_on,
  input wire logic [15:0] tone_compare,
  input wire logic [2:0]  phase_code,
  input wire logic [3:0]  step_index
);

  // The gate and the compare word describe the same tone.
  a_gate_matches_word: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (tone_on == (tone_compare != 16'hFFFF)))
    else $error("tone gate disagrees with compare word");

  // A note phase always sounds; wait and rest are always silent.
  a_phase_tone: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((phase_code == bms_pkg::PH_NOTE) == tone_on ||
                   (phase_code == bms_pkg::PH_HOLD)))
    else $error("tone gate inconsistent with phase");

  // Waiting and end hold always sit at the first step.
  a_idle_step_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (phase_code == bms_pkg::PH_WAIT || phase_code == bms_pkg::PH_HOLD))
      |-> step_index == 4'd0)
    else $error("step not cleared outside play");

  // A stalled result holds its content.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(tone_compare) &&
                                  $stable(phase_code) && $stable(step_index)))
    else $error("stalled result changed");

endmodule

bind button_melody_sequencer bms_checker u_bms_checker (.*);
`default_nettype wire

[sim/bms_tone_checker.sv]
// ----------------------------------------------------------------------------
// bms_tone_checker
// Watches the tick and result channels of the melody sequencer, keeps its own
// copy of the sequencer state and registers, and compares each result
// transaction with the tone status predicted for the matching tick.
// ----------------------------------------------------------------------------
module bms_tone_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  button_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        tone_on,
  input  logic [15:0] tone_compare,
  input  logic        restart_counter,
  input  logic [2:0]  phase_code,
  input  logic [3:0]  step_index,
  input  logic        cfg_write_en,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          error_count,
  output int          status_backlog
);

  typedef struct packed {
    logic        gate;
    logic [15:0] word;
    logic        restart;
    logic [2:0]  phase;
    logic [3:0]  step;
  } tone_status_t;

  // Predicted sequencer state and register copies.
  bms_pkg::phase_t seq_phase;
  logic [3:0]      seq_step;
  logic [7:0]      tick_cnt;
  bms_pkg::tone_t  held_tone;
  logic [7:0]      note_len;
  logic [7:0]      rest_len;
  logic [3:0]      final_step;

  tone_status_t expected_status[$];

  initial begin
    error_count    = 0;
    status_backlog = 0;
  end

  // Divider compare word of a tone: 8 MHz / (128 * f), truncated, minus one.
  function automatic logic [15:0] divider_word(input bms_pkg::tone_t tone);
    case (tone)
      3'd1: return 16'd141;
      3'd2: return 16'd188;
      3'd3: return 16'd211;
      3'd4: return 16'd118;
      3'd5: return 16'd125;
      3'd6: return 16'd158;
      default: return 16'hFFFF;
    endcase
  endfunction

  // Tone of each step of the fixed tune.
  function automatic bms_pkg::tone_t song_tone(input logic [3:0] idx);
    case (idx)
      4'd0, 4'd7, 4'd15: return 3'd1;
      4'd1: return 3'd2;
      4'd2, 4'd10: return 3'd3;
      4'd3, 4'd5, 4'd9, 4'd11: return 3'd4;
      4'd4, 4'd6, 4'd8, 4'd12, 4'd14: return 3'd5;
      default: return 3'd6;
    endcase
  endfunction

  // Moves the predicted sequencer on by one tick and queues the status it shows.
  task automatic advance_sequencer(input logic [7:0] btn);
    tone_status_t   status;
    bms_pkg::tone_t wanted;
    logic           restart;
    restart = 1'b0;
    case (seq_phase)
      bms_pkg::PH_START: begin
        seq_phase = bms_pkg::PH_WAIT;
        seq_step  = 4'd0;
        tick_cnt  = 8'd0;
      end
      bms_pkg::PH_WAIT: begin
        if (btn == bms_pkg::BUTTON_PRESS) begin
          seq_phase = bms_pkg::PH_NOTE;
          tick_cnt  = 8'd0;
        end
      end
      bms_pkg::PH_NOTE: begin
        if (tick_cnt >= note_len) begin
          tick_cnt  = 8'd0;
          seq_phase = bms_pkg::PH_REST;
        end
      end
      bms_pkg::PH_REST: begin
        if (tick_cnt >= rest_len) begin
          if (seq_step < final_step) begin
            seq_step  = seq_step + 4'd1;
            seq_phase = bms_pkg::PH_NOTE;
          end else if (btn == bms_pkg::BUTTON_RELEASE) begin
            seq_step  = 4'd0;
            seq_phase = bms_pkg::PH_WAIT;
          end else if (btn == bms_pkg::BUTTON_PRESS) begin
            seq_step  = 4'd0;
            seq_phase = bms_pkg::PH_HOLD;
          end
        end
      end
      bms_pkg::PH_HOLD: begin
        if (btn != bms_pkg::BUTTON_PRESS) begin
          seq_phase = bms_pkg::PH_WAIT;
          seq_step  = 4'd0;
        end
      end
      default: seq_phase = bms_pkg::PH_WAIT;
    endcase

    // The tick counter runs through both note and rest; the hold phase keeps
    // whatever tone was last set.
    wanted = held_tone;
    case (seq_phase)
      bms_pkg::PH_WAIT: wanted = bms_pkg::TONE_SILENT;
      bms_pkg::PH_NOTE: begin
        tick_cnt = tick_cnt + 8'd1;
        wanted   = song_tone(seq_step);
      end
      bms_pkg::PH_REST: begin
        tick_cnt = tick_cnt + 8'd1;
        wanted   = bms_pkg::TONE_SILENT;
      end
      default: ;
    endcase
    if (wanted != held_tone) begin
      restart   = 1'b1;
      held_tone = wanted;
    end

    status.gate    = (held_tone != bms_pkg::TONE_SILENT);
    status.word    = divider_word(held_tone);
    status.restart = restart;
    status.phase   = seq_phase;
    status.step    = seq_step;
    expected_status.push_back(status);
  endtask

  task automatic check_field(input string label, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    tone_status_t want;
    if (rst) begin
      seq_phase  = bms_pkg::PH_START;
      seq_step   = 4'd0;
      tick_cnt   = 8'd0;
      held_tone  = bms_pkg::TONE_SILENT;
      note_len   = bms_pkg::NOTE_TICKS_RESET;
      rest_len   = bms_pkg::REST_TICKS_RESET;
      final_step = bms_pkg::LAST_STEP_RESET;
      expected_status.delete();
    end else begin
      // The result leaving at this edge belongs to an earlier tick, so it is
      // matched before the tick entering at this edge is predicted.
      if (out_valid && !out_stall) begin
        if (expected_status.size() == 0) begin
          $display("%0t: result transaction with no expected status waiting", $time);
          error_count++;
        end else begin
          want = expected_status.pop_front();
          check_field("tone_on", want.gate, tone_on);
          check_field("tone_compare", want.word, tone_compare);
          check_field("restart_counter", want.restart, restart_counter);
          check_field("phase_code", want.phase, phase_code);
          check_field("step_index", want.step, step_index);
        end
      end
      // A tick entering at this edge still sees the old register values.
      if (in_valid && !in_stall) advance_sequencer(button_byte);
      if (cfg_write_en) begin
        case (cfg_index)
          bms_pkg::REG_NOTE_TICKS: note_len   = cfg_data;
          bms_pkg::REG_REST_TICKS: rest_len   = cfg_data;
          bms_pkg::REG_LAST_STEP:  final_step = cfg_data[3:0];
          default: ;
        endcase
      end
    end
    status_backlog = expected_status.size();
  end

endmodule

[sim/tb_button_melody_sequencer.sv]
// ----------------------------------------------------------------------------
// tb_button_melody_sequencer
// Drives button ticks and register settings into the melody sequencer with
// random idling on both channels; a checker beside the block predicts every
// tone status and counts mismatches, and this top gives the verdict.
// ----------------------------------------------------------------------------
module tb_button_melody_sequencer;

  // Cycles with no transaction on either channel before the run is abandoned.
  // The longest correct quiet stretch is the long receiver hold plus a gap,
  // well under this.
  localparam int QUIET_LIMIT = 2000;
  // Index that maps to no register; writes to it must change nothing.
  localparam logic [1:0] REG_UNUSED = 2'd3;
  // Length of the deliberate receiver hold that backs the block up.
  localparam int unsigned LONG_HOLD = 80;
  localparam int RANDOM_PHASES    = 10;
  localparam int ITEMS_PER_PHASE  = 50;
  localparam int LINGER_ITEMS     = 260;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  button_byte;
  logic        out_valid;
  logic        out_stall;
  logic        tone_on;
  logic [15:0] tone_compare;
  logic        restart_counter;
  logic [2:0]  phase_code;
  logic [3:0]  step_index;
  logic        cfg_write_en;
  logic [1:0]  cfg_index;
  logic [7:0]  cfg_data;

  int          error_count;
  int          status_backlog;
  int          quiet_cycles;

  // Idle settings for the sender and the receiver; the main process
  // changes them between phases.
  int unsigned gap_max;
  int unsigned wait_max;
  bit          long_hold_req;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  button_melody_sequencer DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .button_byte     (button_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .tone_on         (tone_on),
    .tone_compare    (tone_compare),
    .restart_counter (restart_counter),
    .phase_code      (phase_code),
    .step_index      (step_index),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  bms_tone_checker u_checker (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .button_byte     (button_byte),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .tone_on         (tone_on),
    .tone_compare    (tone_compare),
    .restart_counter (restart_counter),
    .phase_code      (phase_code),
    .step_index      (step_index),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .error_count     (error_count),
    .status_backlog  (status_backlog)
  );

  // Watchdog: any cycle that moves a transaction on either side restarts the
  // count, so only a real hang or a lost result can trip it.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result side. Before every result transaction the receiver stalls for a
  // random number of cycles, or for the long hold when the main process asks
  // for one, then takes the next result as soon as it shows up.
  initial begin
    int unsigned hold;
    out_stall = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (long_hold_req) begin
        hold          = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        hold = $urandom_range(0, wait_max);
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  // Offers one tick after a random gap and returns at the edge that accepts
  // it. Valid is left high so that back-to-back ticks need no extra edge.
  task automatic send_tick(input logic [7:0] btn);
    int unsigned gap;
    gap = $urandom_range(0, gap_max);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    button_byte <= btn;
    do @(posedge clk); while (in_stall);
  endtask

  // Stops offering ticks and waits until every predicted status has come
  // back. The block makes one result per tick, so an empty backlog leaves it
  // with nothing in flight.
  task automatic drain;
    in_valid <= 1'b0;
    do @(negedge clk); while (status_backlog != 0);
    repeat (3) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges while the block is idle.
  // The sequencer state itself carries over, so a lower last step can land
  // in the middle of a tune.
  task automatic apply_settings(input logic [7:0] note_len, input logic [7:0] rest_len,
                                input logic [3:0] final_step);
    drain();
    cfg_write_en <= 1'b1;
    cfg_index    <= bms_pkg::REG_NOTE_TICKS;
    cfg_data     <= note_len;
    @(posedge clk);
    cfg_index    <= bms_pkg::REG_REST_TICKS;
    cfg_data     <= rest_len;
    @(posedge clk);
    cfg_index    <= bms_pkg::REG_LAST_STEP;
    cfg_data     <= {4'd0, final_step};
    @(posedge clk);
    cfg_write_en <= 1'b0;
  endtask

  // Button bytes weighted toward release and press, since only those two
  // values steer the sequencer; the rest still covers every byte value.
  function automatic logic [7:0] pick_button();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return bms_pkg::BUTTON_RELEASE;
    if (roll < 70) return bms_pkg::BUTTON_PRESS;
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    logic [7:0] note_len;
    logic [7:0] rest_len;
    logic [3:0] final_step;
    rst           = 1'b1;
    in_valid      = 1'b0;
    button_byte   = 8'd0;
    cfg_write_en  = 1'b0;
    cfg_index     = bms_pkg::REG_NOTE_TICKS;
    cfg_data      = 8'd0;
    gap_max       = 0;
    wait_max      = 0;
    long_hold_req = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Under the reset settings the first tick leaves the start
    // phase, a press starts the tune, and odd bytes during play are ignored.
    send_tick(8'h00);
    send_tick(bms_pkg::BUTTON_PRESS);
    send_tick(8'hFF);
    send_tick(8'h80);
    send_tick(8'h7F);
    send_tick(8'h55);
    send_tick(8'hAA);

    // Zero-length note and rest, and last step dropped to zero while the tune
    // is already past it, so play ends at the next rest. At the final rest an
    // odd byte keeps resting, a press goes to the end hold, a different byte
    // leaves the hold, and a release after a rest returns to wait.
    apply_settings(8'd0, 8'd0, 4'd0);
    cfg_write_en <= 1'b1;
    cfg_index    <= REG_UNUSED;
    cfg_data     <= 8'hA5;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    send_tick(8'h02);
    send_tick(8'h03);
    send_tick(bms_pkg::BUTTON_PRESS);
    send_tick(bms_pkg::BUTTON_PRESS);
    send_tick(8'h04);
    send_tick(bms_pkg::BUTTON_PRESS);
    send_tick(bms_pkg::BUTTON_RELEASE);
    send_tick(bms_pkg::BUTTON_RELEASE);

    // Longest note and rest with the full tune.
    apply_settings(8'd255, 8'd255, 4'd15);
    send_tick(bms_pkg::BUTTON_PRESS);
    send_tick(bms_pkg::BUTTON_RELEASE);
    send_tick(bms_pkg::BUTTON_RELEASE);

    // Random part. The first phases hit the register extremes, the rest use
    // short notes and rests so that whole tunes play out many times. Every
    // third phase runs with no idling at all on either side.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: begin note_len = 8'd0;   rest_len = 8'd0;   final_step = 4'd15; end
        1: begin note_len = 8'd255; rest_len = 8'd255; final_step = 4'd15; end
        2: begin note_len = 8'd0;   rest_len = 8'd255; final_step = 4'd1;  end
        3: begin note_len = 8'd255; rest_len = 8'd0;   final_step = 4'd0;  end
        default: begin
          note_len   = 8'($urandom_range(0, 5));
          rest_len   = 8'($urandom_range(0, 5));
          final_step = 4'($urandom_range(0, 15));
        end
      endcase
      apply_settings(note_len, rest_len, final_step);
      if (p % 3 == 0) begin
        gap_max  = 0;
        wait_max = 0;
      end else begin
        gap_max  = 10;
        wait_max = 10;
      end
      // One phase backs the block up: the receiver holds off for a long
      // stretch while the sender keeps ticks coming, so the input stalls.
      if (p == 4) begin
        gap_max       = 1;
        long_hold_req = 1'b1;
      end
      for (int i = 0; i < ITEMS_PER_PHASE; i++) send_tick(pick_button());
    end

    // Final rest that never ends: with the last step at zero, releases bring
    // the sequencer back to wait, a press starts it, and a long run of bytes
    // other than press and release keeps it resting until the tick counter
    // wraps past 255.
    apply_settings(8'd2, 8'd1, 4'd0);
    gap_max  = 3;
    wait_max = 3;
    repeat (8) send_tick(bms_pkg::BUTTON_RELEASE);
    send_tick(bms_pkg::BUTTON_PRESS);
    for (int i = 0; i < LINGER_ITEMS; i++) send_tick(8'($urandom_range(2, 255)));
    repeat (4) send_tick(pick_button());

    // Wait for the last results, then a few more cycles in case anything
    // unexpected trails out of the block.
    drain();
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
